FILE: rtl/core/strongly_connected_components_defines.svh
// Assertion macros used by the checker file of the block.
`ifndef STRONGLY_CONNECTED_COMPONENTS_DEFINES_SVH
`define STRONGLY_CONNECTED_COMPONENTS_DEFINES_SVH

// Check a condition that must hold in the same cycle as the trigger.
`define SCC_ASSERT_NOW(label, trig, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cond)) \
    else $error("assertion failed");

// Check a condition that must hold in the cycle after the trigger.
`define SCC_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/scc_pkg.sv
// Types and constants of the strongly connected components block.
package scc_pkg;

  localparam int unsigned FIELD_W = 10;
  localparam int unsigned VC_W    = 11;
  localparam int unsigned APB_DW  = 32;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2
  } scc_op_e;

  typedef enum logic [5:0] {
    S_IDLE, S_CLR,
    S_FC_RD, S_FC_CHK, S_FC_INC,
    S_FP_RD, S_FP_ADD,
    S_FF_RD, S_FF_CHK, S_FF_WR,
    S_RC_RD, S_RC_CHK, S_RC_INC,
    S_RP_RD, S_RP_ADD,
    S_RF_V, S_RF_B, S_RF_K, S_RF_U, S_RF_W,
    S_D_V, S_D_VC, S_D_S1, S_D_S2, S_D_S3, S_D_TOP, S_D_NB, S_D_NV, S_D_POP,
    S_C_K, S_C_KR, S_C_KC, S_C_POP, S_C_W, S_C_WS, S_C_WE, S_C_J, S_C_U, S_C_UC,
    S_Q_A, S_Q_B, S_Q_C, S_Q_DONE
  } scc_state_e;

  typedef struct packed {
    logic start;
    logic build;
    logic ack;
  } scc_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } scc_stat_t;

endpackage

FILE: rtl/core/strongly_connected_components.sv
// Top level: strongly connected components of a directed graph, edge store and ports.
// Clear and add-edge transactions leave the block idle; the next item follows at once.
// A query on an unchanged graph goes straight to the lookup; the next item is taken once the result is registered.
// A query after a change first rebuilds the adjacency memories and reruns both passes,
// stepped by the one sequencer.
// Reset clears control state only; the build sweep clears the count, visited and component memories.
module strongly_connected_components #(
  parameter int unsigned MAX_VERTICES = 1024,
  parameter int unsigned MAX_EDGES    = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // op[1:0], src_vertex[11:2], dst_vertex[21:12]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // same_component[0], first_component[10:1],
                                      // second_component[20:11], edges_dropped[21]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned VW  = $clog2(MAX_VERTICES);
  localparam int unsigned NW  = VW + 1;
  localparam int unsigned ETW = $clog2(MAX_EDGES + 1);
  localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned FW  = scc_pkg::FIELD_W;

  logic [scc_pkg::VC_W-1:0] vc_q;
  logic [ETW-1:0]           etot_q;
  logic                     chg_q, drop_q;
  logic [VW-1:0]            qa_q, qb_q;
  logic                     aok_q, bok_q;
  logic                     mv_q, o_same_q, o_drop_q;
  logic [FW-1:0]            o_first_q, o_second_q;

  logic [NW-1:0]            n;
  scc_pkg::scc_op_e         op;
  logic [FW-1:0]            src, dst;
  logic                     acc, aok, bok, full, add_ok, cfg_we, out_free;
  logic [EAW-1:0]           edge_raddr;
  logic [2*VW-1:0]          edge_rdata;
  scc_pkg::scc_ctrl_t       ctrl;
  scc_pkg::scc_stat_t       stat;
  logic [VW-1:0]            ca, cb;
  logic [FW-1:0]            first_c, second_c;

  assign op   = scc_pkg::scc_op_e'(s_axis_tdata[1:0]);
  assign src  = s_axis_tdata[11:2];
  assign dst  = s_axis_tdata[21:12];
  assign n    = (32'(vc_q) > 32'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(vc_q);
  assign aok  = 32'(src) < 32'(n);
  assign bok  = 32'(dst) < 32'(n);
  assign full = 32'(etot_q) >= 32'(MAX_EDGES);
  assign add_ok = !full && aok && bok;

  assign s_axis_tready = !stat.busy;
  assign acc      = s_axis_tvalid && s_axis_tready;
  assign cfg_we   = psel && penable && pwrite && pready;
  assign out_free = !mv_q || m_axis_tready;

  assign ctrl.start = acc && (op == scc_pkg::OP_QUERY);
  assign ctrl.build = chg_q;
  assign ctrl.ack   = out_free;

  assign pready = 1'b1;
  assign prdata = scc_pkg::APB_DW'(vc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q   <= scc_pkg::VC_W'(1);
      etot_q <= '0;
      chg_q  <= 1'b1;
      drop_q <= 1'b0;
      mv_q   <= 1'b0;
    end else begin
      if (cfg_we) begin
        vc_q  <= pwdata[scc_pkg::VC_W-1:0];
        chg_q <= 1'b1;
      end
      if (acc) begin
        unique case (op)
          scc_pkg::OP_CLEAR: begin
            etot_q <= '0;
            drop_q <= 1'b0;
            chg_q  <= 1'b1;
          end
          scc_pkg::OP_ADD: begin
            if (add_ok) begin
              etot_q <= ETW'(etot_q + ETW'(1));
              chg_q  <= 1'b1;
            end else begin
              drop_q <= 1'b1;
            end
          end
          scc_pkg::OP_QUERY: chg_q <= 1'b0;
          default: ;
        endcase
      end
      if (stat.done && out_free) begin
        mv_q <= 1'b1;
      end else if (m_axis_tready) begin
        mv_q <= 1'b0;
      end
    end
  end

  assign first_c  = aok_q ? FW'(ca) : '0;
  assign second_c = bok_q ? FW'(cb) : '0;

  always_ff @(posedge clk_i) begin
    if (ctrl.start) begin
      qa_q  <= VW'(src);
      qb_q  <= VW'(dst);
      aok_q <= aok;
      bok_q <= bok;
    end
    if (stat.done && out_free) begin
      o_same_q   <= aok_q && bok_q && (ca == cb);
      o_first_q  <= first_c;
      o_second_q <= second_c;
      o_drop_q   <= drop_q;
    end
  end

  scc_ram #(.WIDTH(2 * VW), .DEPTH(MAX_EDGES)) u_edges (
    .clk_i,
    .we_i   (acc && (op == scc_pkg::OP_ADD) && add_ok),
    .waddr_i(etot_q[EAW-1:0]),
    .wdata_i({VW'(dst), VW'(src)}),
    .raddr_i(edge_raddr),
    .rdata_o(edge_rdata)
  );

  scc_walk #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_walk (
    .clk_i,
    .rst_ni,
    .ctrl_i      (ctrl),
    .n_i         (n),
    .edge_total_i(etot_q),
    .qa_i        (qa_q),
    .qb_i        (qb_q),
    .edge_raddr_o(edge_raddr),
    .edge_rdata_i(edge_rdata),
    .stat_o      (stat),
    .ca_o        (ca),
    .cb_o        (cb)
  );

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = {2'b00, o_drop_q, o_second_q, o_first_q, o_same_q};

endmodule

FILE: rtl/core/scc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module scc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/scc_walk.sv
// Build and query sequencer: adjacency build, two depth-first passes, lookup.
module scc_walk #(
  parameter int unsigned MAX_VERTICES = 1024,
  parameter int unsigned MAX_EDGES    = 4096,
  localparam int unsigned VW  = $clog2(MAX_VERTICES),
  localparam int unsigned NW  = VW + 1,
  localparam int unsigned ETW = $clog2(MAX_EDGES + 1),
  localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  scc_pkg::scc_ctrl_t ctrl_i,
  input  logic [NW-1:0]      n_i,
  input  logic [ETW-1:0]     edge_total_i,
  input  logic [VW-1:0]      qa_i,
  input  logic [VW-1:0]      qb_i,
  output logic [EAW-1:0]     edge_raddr_o,
  input  logic [2*VW-1:0]    edge_rdata_i,
  output scc_pkg::scc_stat_t stat_o,
  output logic [VW-1:0]      ca_o,
  output logic [VW-1:0]      cb_o
);

  localparam int unsigned SAW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned STW = VW + 2 * ETW;

  scc_pkg::scc_state_e state_q, state_d;

  logic [NW-1:0]  v_q, v_d, top_q, top_d, done_q, done_d, k_q, k_d, nc_q, nc_d;
  logic [ETW-1:0] e_q, e_d, sum_q, sum_d, tot_q, tot_d, bnd_q, bnd_d;
  logic [ETW-1:0] tc_q, tc_d, tend_q, tend_d, j_q, j_d, jend_q, jend_d;
  logic [VW-1:0]  u_q, u_d, s_q, s_d, tw_q, tw_d, ca_q, ca_d, cb_q, cb_d;

  logic           fs_we, rs_we, fn_we, rn_we, fp_we, vis_we, fo_we, cm_we, st_we;
  logic [SAW-1:0] fs_wa, fs_ra, rs_wa, rs_ra;
  logic [ETW-1:0] fs_wd, fs_rd, rs_wd, rs_rd;
  logic [EAW-1:0] fn_wa, fn_ra, rn_wa, rn_ra;
  logic [VW-1:0]  fn_wd, fn_rd, rn_wd, rn_rd;
  logic [VW-1:0]  fp_wa, fp_ra, vis_wa, vis_ra, fo_wa, fo_ra, cm_wa, cm_ra;
  logic [VW-1:0]  st_wa, st_ra;
  logic [ETW-1:0] fp_wd, fp_rd;
  logic [0:0]     vis_wd, vis_rd;
  logic [VW-1:0]  fo_wd, fo_rd;
  logic [VW:0]    cm_wd, cm_rd;
  logic [STW-1:0] st_wd, st_rd;

  logic [VW-1:0]  e_src, e_dst;
  logic           e_ok;

  assign e_src = edge_rdata_i[VW-1:0];
  assign e_dst = edge_rdata_i[2*VW-1:VW];
  assign e_ok  = (NW'(e_src) < n_i) && (NW'(e_dst) < n_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      scc_pkg::S_IDLE:   if (ctrl_i.start) state_d = ctrl_i.build ? scc_pkg::S_CLR
                                                                  : scc_pkg::S_Q_A;
      scc_pkg::S_CLR:    if (v_q == n_i) state_d = scc_pkg::S_FC_RD;
      scc_pkg::S_FC_RD:  state_d = (e_q == edge_total_i) ? scc_pkg::S_FP_RD
                                                          : scc_pkg::S_FC_CHK;
      scc_pkg::S_FC_CHK: state_d = e_ok ? scc_pkg::S_FC_INC : scc_pkg::S_FC_RD;
      scc_pkg::S_FC_INC: state_d = scc_pkg::S_FC_RD;
      scc_pkg::S_FP_RD:  state_d = (v_q == n_i) ? scc_pkg::S_FF_RD : scc_pkg::S_FP_ADD;
      scc_pkg::S_FP_ADD: state_d = scc_pkg::S_FP_RD;
      scc_pkg::S_FF_RD:  state_d = (e_q == edge_total_i) ? scc_pkg::S_RC_RD
                                                          : scc_pkg::S_FF_CHK;
      scc_pkg::S_FF_CHK: state_d = e_ok ? scc_pkg::S_FF_WR : scc_pkg::S_FF_RD;
      scc_pkg::S_FF_WR:  state_d = scc_pkg::S_FF_RD;
      scc_pkg::S_RC_RD:  state_d = (e_q == tot_q) ? scc_pkg::S_RP_RD : scc_pkg::S_RC_CHK;
      scc_pkg::S_RC_CHK: state_d = scc_pkg::S_RC_INC;
      scc_pkg::S_RC_INC: state_d = scc_pkg::S_RC_RD;
      scc_pkg::S_RP_RD:  state_d = (v_q == n_i) ? scc_pkg::S_RF_V : scc_pkg::S_RP_ADD;
      scc_pkg::S_RP_ADD: state_d = scc_pkg::S_RP_RD;
      scc_pkg::S_RF_V:   state_d = (v_q == n_i) ? scc_pkg::S_D_V : scc_pkg::S_RF_B;
      scc_pkg::S_RF_B:   state_d = scc_pkg::S_RF_K;
      scc_pkg::S_RF_K:   state_d = (e_q < bnd_q) ? scc_pkg::S_RF_U : scc_pkg::S_RF_V;
      scc_pkg::S_RF_U:   state_d = scc_pkg::S_RF_W;
      scc_pkg::S_RF_W:   state_d = scc_pkg::S_RF_K;
      scc_pkg::S_D_V:    state_d = (v_q == n_i) ? scc_pkg::S_C_K : scc_pkg::S_D_VC;
      scc_pkg::S_D_VC:   state_d = vis_rd[0] ? scc_pkg::S_D_V : scc_pkg::S_D_S1;
      scc_pkg::S_D_S1:   state_d = scc_pkg::S_D_S2;
      scc_pkg::S_D_S2:   state_d = scc_pkg::S_D_S3;
      scc_pkg::S_D_S3:   state_d = scc_pkg::S_D_TOP;
      scc_pkg::S_D_TOP: begin
        if (tc_q < tend_q) state_d = scc_pkg::S_D_NB;
        else if (top_q == NW'(1)) state_d = scc_pkg::S_D_V;
        else state_d = scc_pkg::S_D_POP;
      end
      scc_pkg::S_D_NB:   state_d = scc_pkg::S_D_NV;
      scc_pkg::S_D_NV:   state_d = vis_rd[0] ? scc_pkg::S_D_TOP : scc_pkg::S_D_S1;
      scc_pkg::S_D_POP:  state_d = scc_pkg::S_D_TOP;
      scc_pkg::S_C_K:    state_d = (k_q == '0) ? scc_pkg::S_Q_A : scc_pkg::S_C_KR;
      scc_pkg::S_C_KR:   state_d = scc_pkg::S_C_KC;
      scc_pkg::S_C_KC:   state_d = cm_rd[VW] ? scc_pkg::S_C_K : scc_pkg::S_C_POP;
      scc_pkg::S_C_POP:  state_d = (top_q == '0) ? scc_pkg::S_C_K : scc_pkg::S_C_W;
      scc_pkg::S_C_W:    state_d = scc_pkg::S_C_WS;
      scc_pkg::S_C_WS:   state_d = scc_pkg::S_C_WE;
      scc_pkg::S_C_WE:   state_d = scc_pkg::S_C_J;
      scc_pkg::S_C_J:    state_d = (j_q < jend_q) ? scc_pkg::S_C_U : scc_pkg::S_C_POP;
      scc_pkg::S_C_U:    state_d = scc_pkg::S_C_UC;
      scc_pkg::S_C_UC:   state_d = scc_pkg::S_C_J;
      scc_pkg::S_Q_A:    state_d = scc_pkg::S_Q_B;
      scc_pkg::S_Q_B:    state_d = scc_pkg::S_Q_C;
      scc_pkg::S_Q_C:    state_d = scc_pkg::S_Q_DONE;
      scc_pkg::S_Q_DONE: if (ctrl_i.ack) state_d = scc_pkg::S_IDLE;
      default:           state_d = scc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    v_d = v_q; top_d = top_q; done_d = done_q; k_d = k_q; nc_d = nc_q;
    e_d = e_q; sum_d = sum_q; tot_d = tot_q; bnd_d = bnd_q;
    tc_d = tc_q; tend_d = tend_q; j_d = j_q; jend_d = jend_q;
    u_d = u_q; s_d = s_q; tw_d = tw_q; ca_d = ca_q; cb_d = cb_q;
    edge_raddr_o = e_q[EAW-1:0];
    fs_we = 1'b0; fs_wa = SAW'(v_q); fs_wd = '0; fs_ra = SAW'(v_q + NW'(1));
    rs_we = 1'b0; rs_wa = SAW'(v_q); rs_wd = '0; rs_ra = SAW'(v_q + NW'(1));
    fn_we = 1'b0; fn_wa = fp_rd[EAW-1:0]; fn_wd = u_q; fn_ra = e_q[EAW-1:0];
    rn_we = 1'b0; rn_wa = fp_rd[EAW-1:0]; rn_wd = VW'(v_q); rn_ra = j_q[EAW-1:0];
    fp_we = 1'b0; fp_wa = VW'(v_q); fp_wd = sum_q; fp_ra = u_q;
    vis_we = 1'b0; vis_wa = VW'(v_q); vis_wd = 1'b0; vis_ra = VW'(v_q);
    fo_we = 1'b0; fo_wa = VW'(done_q); fo_wd = tw_q; fo_ra = VW'(k_q - NW'(1));
    cm_we = 1'b0; cm_wa = u_q; cm_wd = {1'b1, VW'(nc_q)}; cm_ra = u_q;
    st_we = 1'b0; st_wa = VW'(top_q); st_wd = {{(2*ETW){1'b0}}, u_q};
    st_ra = VW'(top_q - NW'(1));
    unique case (state_q)
      scc_pkg::S_IDLE: begin
        v_d = '0;
        e_d = '0;
      end
      scc_pkg::S_CLR: begin
        fs_we = 1'b1;
        rs_we = 1'b1;
        if (v_q < n_i) begin
          vis_we = 1'b1;
          cm_we  = 1'b1;
          cm_wa  = VW'(v_q);
          cm_wd  = '0;
        end
        v_d = NW'(v_q + NW'(1));
      end
      scc_pkg::S_FC_RD: begin
        sum_d = '0;
        v_d   = '0;
      end
      scc_pkg::S_FC_CHK: begin
        fs_ra = SAW'(NW'(e_src) + NW'(1));
        s_d   = e_src;
        if (!e_ok) e_d = ETW'(e_q + ETW'(1));
      end
      scc_pkg::S_FC_INC: begin
        fs_we = 1'b1;
        fs_wa = SAW'(NW'(s_q) + NW'(1));
        fs_wd = ETW'(fs_rd + ETW'(1));
        e_d   = ETW'(e_q + ETW'(1));
      end
      scc_pkg::S_FP_RD: begin
        tot_d = sum_q;
        e_d   = '0;
      end
      scc_pkg::S_FP_ADD: begin
        fs_we = 1'b1;
        fs_wa = SAW'(v_q + NW'(1));
        fs_wd = ETW'(sum_q + fs_rd);
        sum_d = ETW'(sum_q + fs_rd);
        fp_we = 1'b1;
        v_d   = NW'(v_q + NW'(1));
      end
      scc_pkg::S_FF_RD: e_d = (e_q == edge_total_i) ? '0 : e_q;
      scc_pkg::S_FF_CHK: begin
        fp_ra = e_src;
        s_d   = e_src;
        u_d   = e_dst;
        if (!e_ok) e_d = ETW'(e_q + ETW'(1));
      end
      scc_pkg::S_FF_WR: begin
        fn_we = 1'b1;
        fp_we = 1'b1;
        fp_wa = s_q;
        fp_wd = ETW'(fp_rd + ETW'(1));
        e_d   = ETW'(e_q + ETW'(1));
      end
      scc_pkg::S_RC_RD: begin
        sum_d = '0;
        v_d   = '0;
      end
      scc_pkg::S_RC_CHK: begin
        rs_ra = SAW'(NW'(fn_rd) + NW'(1));
        u_d   = fn_rd;
      end
      scc_pkg::S_RC_INC: begin
        rs_we = 1'b1;
        rs_wa = SAW'(NW'(u_q) + NW'(1));
        rs_wd = ETW'(rs_rd + ETW'(1));
        e_d   = ETW'(e_q + ETW'(1));
      end
      scc_pkg::S_RP_RD: begin
        if (v_q == n_i) v_d = '0;
        e_d = '0;
      end
      scc_pkg::S_RP_ADD: begin
        rs_we = 1'b1;
        rs_wa = SAW'(v_q + NW'(1));
        rs_wd = ETW'(sum_q + rs_rd);
        sum_d = ETW'(sum_q + rs_rd);
        fp_we = 1'b1;
        v_d   = NW'(v_q + NW'(1));
      end
      scc_pkg::S_RF_V: begin
        if (v_q == n_i) v_d = '0;
        done_d = '0;
      end
      scc_pkg::S_RF_B: bnd_d = fs_rd;
      scc_pkg::S_RF_K: if (!(e_q < bnd_q)) v_d = NW'(v_q + NW'(1));
      scc_pkg::S_RF_U: begin
        u_d   = fn_rd;
        fp_ra = fn_rd;
      end
      scc_pkg::S_RF_W: begin
        rn_we = 1'b1;
        fp_we = 1'b1;
        fp_wa = u_q;
        fp_wd = ETW'(fp_rd + ETW'(1));
        e_d   = ETW'(e_q + ETW'(1));
      end
      scc_pkg::S_D_V: begin
        k_d  = done_q;
        nc_d = '0;
      end
      scc_pkg::S_D_VC: begin
        if (vis_rd[0]) begin
          v_d = NW'(v_q + NW'(1));
        end else begin
          vis_we = 1'b1;
          vis_wd = 1'b1;
          u_d    = VW'(v_q);
          top_d  = '0;
        end
      end
      scc_pkg::S_D_S1: fs_ra = SAW'(u_q);
      scc_pkg::S_D_S2: begin
        tc_d  = fs_rd;
        fs_ra = SAW'(NW'(u_q) + NW'(1));
      end
      scc_pkg::S_D_S3: begin
        tend_d = fs_rd;
        tw_d   = u_q;
        top_d  = NW'(top_q + NW'(1));
      end
      scc_pkg::S_D_TOP: begin
        fn_ra = tc_q[EAW-1:0];
        if (!(tc_q < tend_q)) begin
          fo_we  = 1'b1;
          done_d = NW'(done_q + NW'(1));
          top_d  = NW'(top_q - NW'(1));
          st_ra  = VW'(top_q - NW'(2));
          if (top_q == NW'(1)) v_d = NW'(v_q + NW'(1));
        end
      end
      scc_pkg::S_D_NB: begin
        u_d    = fn_rd;
        vis_ra = fn_rd;
      end
      scc_pkg::S_D_NV: begin
        if (vis_rd[0]) begin
          tc_d = ETW'(tc_q + ETW'(1));
        end else begin
          vis_we = 1'b1;
          vis_wa = u_q;
          vis_wd = 1'b1;
          st_we  = 1'b1;
          st_wa  = VW'(top_q - NW'(1));
          st_wd  = {tend_q, ETW'(tc_q + ETW'(1)), tw_q};
        end
      end
      scc_pkg::S_D_POP: begin
        tw_d   = st_rd[VW-1:0];
        tc_d   = st_rd[VW+ETW-1:VW];
        tend_d = st_rd[STW-1:VW+ETW];
      end
      scc_pkg::S_C_K: ;
      scc_pkg::S_C_KR: begin
        u_d   = fo_rd;
        cm_ra = fo_rd;
      end
      scc_pkg::S_C_KC: begin
        if (cm_rd[VW]) begin
          k_d = NW'(k_q - NW'(1));
        end else begin
          cm_we = 1'b1;
          st_we = 1'b1;
          st_wa = '0;
          top_d = NW'(1);
        end
      end
      scc_pkg::S_C_POP: begin
        if (top_q == '0) begin
          nc_d = NW'(nc_q + NW'(1));
          k_d  = NW'(k_q - NW'(1));
        end else begin
          top_d = NW'(top_q - NW'(1));
        end
      end
      scc_pkg::S_C_W: begin
        tw_d  = st_rd[VW-1:0];
        rs_ra = SAW'(st_rd[VW-1:0]);
      end
      scc_pkg::S_C_WS: begin
        j_d   = rs_rd;
        rs_ra = SAW'(NW'(tw_q) + NW'(1));
      end
      scc_pkg::S_C_WE: jend_d = rs_rd;
      scc_pkg::S_C_J: ;
      scc_pkg::S_C_U: begin
        u_d   = rn_rd;
        cm_ra = rn_rd;
      end
      scc_pkg::S_C_UC: begin
        if (!cm_rd[VW]) begin
          cm_we = 1'b1;
          st_we = 1'b1;
          top_d = NW'(top_q + NW'(1));
        end
        j_d = ETW'(j_q + ETW'(1));
      end
      scc_pkg::S_Q_A: cm_ra = qa_i;
      scc_pkg::S_Q_B: begin
        ca_d  = cm_rd[VW-1:0];
        cm_ra = qb_i;
      end
      scc_pkg::S_Q_C: cb_d = cm_rd[VW-1:0];
      scc_pkg::S_Q_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= scc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d; top_q <= top_d; done_q <= done_d; k_q <= k_d; nc_q <= nc_d;
    e_q <= e_d; sum_q <= sum_d; tot_q <= tot_d; bnd_q <= bnd_d;
    tc_q <= tc_d; tend_q <= tend_d; j_q <= j_d; jend_q <= jend_d;
    u_q <= u_d; s_q <= s_d; tw_q <= tw_d; ca_q <= ca_d; cb_q <= cb_d;
  end

  scc_ram #(.WIDTH(ETW), .DEPTH(MAX_VERTICES + 1)) u_fs (
    .clk_i, .we_i(fs_we), .waddr_i(fs_wa), .wdata_i(fs_wd), .raddr_i(fs_ra), .rdata_o(fs_rd)
  );
  scc_ram #(.WIDTH(ETW), .DEPTH(MAX_VERTICES + 1)) u_rs (
    .clk_i, .we_i(rs_we), .waddr_i(rs_wa), .wdata_i(rs_wd), .raddr_i(rs_ra), .rdata_o(rs_rd)
  );
  scc_ram #(.WIDTH(VW), .DEPTH(MAX_EDGES)) u_fn (
    .clk_i, .we_i(fn_we), .waddr_i(fn_wa), .wdata_i(fn_wd), .raddr_i(fn_ra), .rdata_o(fn_rd)
  );
  scc_ram #(.WIDTH(VW), .DEPTH(MAX_EDGES)) u_rn (
    .clk_i, .we_i(rn_we), .waddr_i(rn_wa), .wdata_i(rn_wd), .raddr_i(rn_ra), .rdata_o(rn_rd)
  );
  scc_ram #(.WIDTH(ETW), .DEPTH(MAX_VERTICES)) u_fp (
    .clk_i, .we_i(fp_we), .waddr_i(fp_wa), .wdata_i(fp_wd), .raddr_i(fp_ra), .rdata_o(fp_rd)
  );
  scc_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_vis (
    .clk_i, .we_i(vis_we), .waddr_i(vis_wa), .wdata_i(vis_wd), .raddr_i(vis_ra),
    .rdata_o(vis_rd)
  );
  scc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_fo (
    .clk_i, .we_i(fo_we), .waddr_i(fo_wa), .wdata_i(fo_wd), .raddr_i(fo_ra), .rdata_o(fo_rd)
  );
  scc_ram #(.WIDTH(VW + 1), .DEPTH(MAX_VERTICES)) u_cm (
    .clk_i, .we_i(cm_we), .waddr_i(cm_wa), .wdata_i(cm_wd), .raddr_i(cm_ra), .rdata_o(cm_rd)
  );
  scc_ram #(.WIDTH(STW), .DEPTH(MAX_VERTICES)) u_st (
    .clk_i, .we_i(st_we), .waddr_i(st_wa), .wdata_i(st_wd), .raddr_i(st_ra), .rdata_o(st_rd)
  );

  assign stat_o.busy = (state_q != scc_pkg::S_IDLE);
  assign stat_o.done = (state_q == scc_pkg::S_Q_DONE);
  assign ca_o = ca_q;
  assign cb_o = cb_q;

endmodule

FILE: rtl/core/scc_chk.sv
// Port-level checker for the strongly connected components block, with its bind.
`include "strongly_connected_components_defines.svh"

module scc_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [23:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        pready
);

  logic in_acc;
  logic in_query;
  logic out_wait;
  logic comp_match;

  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign in_query   = (s_axis_tdata[1:0] == scc_pkg::OP_QUERY);
  assign out_wait   = m_axis_tvalid && !m_axis_tready;
  assign comp_match = (m_axis_tdata[10:1] == m_axis_tdata[20:11]);

  `SCC_ASSERT_NEXT(a_query_blocks, in_acc && in_query, !s_axis_tready)
  `SCC_ASSERT_NEXT(a_edge_no_result, in_acc && !in_query, !$rose(m_axis_tvalid))
  `SCC_ASSERT_NOW(a_same_zero_comp, m_axis_tvalid && m_axis_tdata[0], comp_match)
  `SCC_ASSERT_NEXT(a_out_hold, out_wait, m_axis_tvalid && $stable(m_axis_tdata))
  `SCC_ASSERT_NOW(a_pready_high, 1'b1, pready)

endmodule

bind strongly_connected_components scc_chk u_scc_chk (.*);
